### design/mie_pkg.sv
// Shared constants and types for the extended Euclidean modular inverse block.
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;

   // Working width of the operands.
   localparam int WIDTH       = 32;
   // Width of each operand field on the request channel.
   localparam int IN_W        = 32;
   // Width of the signed coefficient.
   localparam int COEF_W      = 33;
   localparam int REQ_TDATA_W = 2 * IN_W;
   localparam int RSP_TDATA_W = ((COEF_W + 7) / 8) * 8;
   localparam int CNT_W       = $clog2(WIDTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_STEP = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

### design/modular_inverse_ext_euclid.sv
// Top level of the extended Euclidean modular inverse block.
`timescale 1ns / 1ps
`default_nettype none
// Each beat runs a sequence of quotient and remainder steps (at most about 46 for 32 bits);
// a zero value takes no step. The bit-serial divider produces one quotient bit per cycle,
// and each step ends with an update of the remainder sequence and the coefficients. A new
// request is accepted only in the idle state. A held result stalls the next item only
// when that item finishes before the result is taken.
// Reset: synchronous and active high; the block comes up idle with no result pending.
module modular_inverse_ext_euclid (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0 up: modulus [31:0], value [63:32].
   input  wire  [mie_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // Fields from bit 0 up: coefficient [32:0] (two's complement), zero fill above.
   output logic [mie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mie_pkg::*;

   // The sequencer walks each item through repeated division steps. In the DIV state
   // a single shift-and-subtract unit produces one quotient bit per cycle, most
   // significant first. The same cycle folds that bit into a running product of
   // quotient times the current coefficient, so no multiplier is needed. The STEP
   // state then rotates the remainder sequence and the coefficient pair.

   state_type           state_ff, state_in;
   logic [WIDTH-1:0]    m_ff, m_in;        // dividend, shifted out during a division
   logic [WIDTH-1:0]    v_ff, v_in;        // divisor
   logic [WIDTH-1:0]    rem_ff, rem_in;    // partial remainder
   logic [COEF_W-1:0]   prev_ff, prev_in;  // previous coefficient of value
   logic [COEF_W-1:0]   cur_ff, cur_in;    // current coefficient of value
   logic [COEF_W-1:0]   prod_ff, prod_in;  // quotient times current coefficient
   logic [CNT_W-1:0]    cnt_ff, cnt_in;    // quotient bits left, minus one
   logic [COEF_W-1:0]   coef_ff, coef_in;  // output register
   logic                rsp_valid_ff, rsp_valid_in;

   // Operands cut (or zero extended) to the working width.
   logic [IN_W+WIDTH-1:0] mod_ext, val_ext;
   logic [WIDTH-1:0]      req_mod, req_val;

   // Shared shift and subtract unit.
   logic [WIDTH:0]      rem_sh, diff;
   logic                qbit;
   logic [COEF_W-1:0]   prod_add;

   assign mod_ext = {{WIDTH{1'b0}}, req_tdata[IN_W-1:0]};
   assign val_ext = {{WIDTH{1'b0}}, req_tdata[2*IN_W-1:IN_W]};
   assign req_mod = mod_ext[WIDTH-1:0];
   assign req_val = val_ext[WIDTH-1:0];

   assign rem_sh   = {rem_ff, m_ff[WIDTH-1]};
   assign diff     = rem_sh - {1'b0, v_ff};
   assign qbit     = ~diff[WIDTH];
   assign prod_add = {prod_ff[COEF_W-2:0], 1'b0} + (qbit ? cur_ff : {COEF_W{1'b0}});

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-COEF_W){1'b0}}, coef_ff};

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      coef_in      = coef_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               m_in    = req_mod;
               v_in    = req_val;
               rem_in  = '0;
               prev_in = '0;
               cur_in  = COEF_W'(1);
               prod_in = '0;
               cnt_in  = CNT_W'(WIDTH - 1);
               // A zero value takes no step and returns a coefficient of one.
               state_in = (req_val == '0) ? ST_FIN : ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            m_in    = {m_ff[WIDTH-2:0], 1'b0};
            prod_in = prod_add;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (rem_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cur_in   = prev_ff - prod_ff;
               prev_in  = cur_ff;
               m_in     = v_ff;
               v_in     = rem_ff;
               rem_in   = '0;
               prod_in  = '0;
               cnt_in   = CNT_W'(WIDTH - 1);
               state_in = ST_DIV;
            end
         end
         ST_FIN: begin
            // Wait here until the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               coef_in      = cur_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      cnt_ff  <= cnt_in;
      coef_ff <= coef_in;
   end

endmodule
`default_nettype wire

### design/mie_checker.sv
// Port-level assertions for the modular inverse block, with the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module mie_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire  [mie_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire  [mie_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mie_pkg::*;

   // After reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // A stalled result beat holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

   // The block works on one item at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // A zero value goes through the FIN state and yields a coefficient of one.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid && (req_tdata[2*IN_W-1:IN_W] == '0))
      |-> ##2 (rsp_tvalid && (rsp_tdata[COEF_W-1:0] == COEF_W'(1))))
      else $error("zero value did not return one");

endmodule

bind modular_inverse_ext_euclid mie_checker u_mie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
